// ----- rtl/core/swm_pkg.sv -----
`timescale 1ns / 1ps

package swm_pkg;

   localparam int SAMPLE_WIDTH = 16;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   // What one cell hands to the next one up the chain. Here, "window" means
   // the sorted window with the departing word already taken out.
   typedef struct packed {
      sample_type val;   // Entry of the compacted window at this cell's slot.
      logic       gt;    // That entry is above the new word (always set at the top slot).
      logic       seen;  // The departing word sits at this slot or below it.
   } link_type;

endpackage

// ----- rtl/core/sliding_window_median.sv -----
`timescale 1ns / 1ps

// Running median over the last WINDOW signed 16-bit samples. The window is
// held sorted in a row of WINDOW cells, each keeping one word and its age;
// every accepted word drops the oldest entry and slots the new one in order
// with one register update of all cells, so the block takes one word per
// clock while results are taken, and returns its median (the sorted entry at
// WINDOW/2, upper median for even WINDOW) in the cycle after. The throughput
// is set by that update across the cell row, whose compare and slot search
// ripple from cell to cell. A result waiting on rsp_ready stalls input only
// until it is taken. After reset the window holds WINDOW zeros.
module sliding_window_median
   import swm_pkg::*;
#(
   parameter int WINDOW = 15
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  sample_type req_sample,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output sample_type rsp_median
);

   localparam int AGE_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   link_type         links    [WINDOW];
   logic [AGE_W-1:0] link_age [WINDOW];
   sample_type       cell_val [WINDOW];
   logic [AGE_W-1:0] cell_age [WINDOW];

   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      link_type         prev_link;
      logic [AGE_W-1:0] prev_age;
      sample_type       next_val;
      logic [AGE_W-1:0] next_age;

      if (i == 0) begin : g_bottom
         assign prev_link = '{val: '0, gt: 1'b0, seen: 1'b0};
         assign prev_age  = '0;
      end else begin : g_mid
         assign prev_link = links[i-1];
         assign prev_age  = link_age[i-1];
      end

      if (i == WINDOW - 1) begin : g_top
         assign next_val = '0;
         assign next_age = '0;
      end else begin : g_below
         assign next_val = cell_val[i+1];
         assign next_age = cell_age[i+1];
      end

      swm_cell #(
         .WINDOW (WINDOW),
         .INDEX  (i),
         .AGE_W  (AGE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (accept),
         .sample    (req_sample),
         .prev_link (prev_link),
         .prev_age  (prev_age),
         .next_val  (next_val),
         .next_age  (next_age),
         .link      (links[i]),
         .link_age  (link_age[i]),
         .val       (cell_val[i]),
         .age       (cell_age[i])
      );
   end

   // The cells hold still while a result waits, so the middle cell is the
   // pending median.
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = cell_val[WINDOW/2];

endmodule

// ----- rtl/core/swm_cell.sv -----
`timescale 1ns / 1ps

module swm_cell
   import swm_pkg::*;
#(
   parameter int WINDOW = 15,
   parameter int INDEX  = 0,
   parameter int AGE_W  = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  sample_type       sample,
   input  link_type         prev_link,
   input  logic [AGE_W-1:0] prev_age,
   input  sample_type       next_val,
   input  logic [AGE_W-1:0] next_age,
   output link_type         link,
   output logic [AGE_W-1:0] link_age,
   output sample_type       val,
   output logic [AGE_W-1:0] age
);

   localparam logic [AGE_W-1:0] OldestAge = AGE_W'(WINDOW - 1);
   localparam logic [AGE_W-1:0] ResetAge  = AGE_W'(INDEX);
   localparam bit               TopCell   = (INDEX == WINDOW - 1);

   sample_type       val_ff, val_in;
   logic [AGE_W-1:0] age_ff, age_in;

   always_comb begin
      // Once the departing word is at or below this slot, the compacted
      // window shifts down by one, so this slot takes the word from above.
      link.seen = prev_link.seen | (age_ff == OldestAge);
      link.val  = link.seen ? next_val : val_ff;
      link_age  = link.seen ? next_age : age_ff;
      link.gt   = TopCell ? 1'b1 : ($signed(link.val) > $signed(sample));

      if (!link.gt) begin
         val_in = link.val;
         age_in = link_age + AGE_W'(1);
      end else if (!prev_link.gt) begin
         val_in = sample;
         age_in = '0;
      end else begin
         val_in = prev_link.val;
         age_in = prev_age + AGE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
         age_ff <= ResetAge;
      end else if (shift_en) begin
         val_ff <= val_in;
         age_ff <= age_in;
      end
   end

   assign val = val_ff;
   assign age = age_ff;

endmodule
